### src/dsq_pkg.sv
// dsq_pkg: shared constants, control structs and the angle table builder
// for the spherical direction quantizer. No dependencies.

package dsq_pkg;

    // field widths
    localparam int IN_W     = 16;
    localparam int OUT_W    = 8;

    // angle table entries: signed Q1.16
    localparam int ROM_W    = 18;
    localparam int ROM_FRAC = 16;

    // parameter defaults
    localparam int ANGLE_STEPS_DEF     = 256;
    localparam int COORD_FRAC_BITS_DEF = 14;

    // Q62 constants for the table builder
    localparam logic [63:0] PI_OVER_2_Q62 = 64'h6487_ED51_10B4_611A;
    localparam logic [63:0] ONE_Q62       = 64'h4000_0000_0000_0000;
    localparam logic [63:0] HALF_LSB_Q16  = 64'h0000_2000_0000_0000;

    // search unit request and status
    typedef struct packed {
        logic start;
        logic polar;
    } t_srch_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_srch_sts;

    // restoring long division, elaboration only
    function automatic logic [63:0] div_u64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        logic [64:0] r;
        int          i;
        q = '0;
        r = '0;
        for (i = 63; i >= 0; i--) begin
            r = {r[63:0], a[i]};
            if (r >= {1'b0, b}) begin
                r    = r - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // (a * b) >> 62
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // Q62 to Q1.16, round to nearest
    function automatic logic signed [ROM_W-1:0] to_q16(input logic [63:0] v, input logic neg);
        logic [63:0]             r;
        logic signed [ROM_W-1:0] t;
        r = (v + HALF_LSB_Q16) >> 46;
        t = {1'b0, r[ROM_W-2:0]};
        return neg ? -t : t;
    endfunction

    // cos or sin of pi*j/n in Q1.16, from a 17-term series at Q62
    function automatic logic signed [ROM_W-1:0] rom_value(input int j, input int n,
                                                          input logic want_sin);
        logic [63:0]             two_j;
        logic [63:0]             nn;
        logic [63:0]             quad;
        logic [63:0]             rr;
        logic [63:0]             qn;
        logic [63:0]             x;
        logic [63:0]             x2;
        logic [63:0]             s;
        logic [63:0]             c;
        logic [63:0]             ts;
        logic [63:0]             tc;
        logic signed [ROM_W-1:0] vc;
        logic signed [ROM_W-1:0] vs;
        int                      i;
        two_j = 64'(2 * j);
        nn    = 64'(n);
        quad  = div_u64(two_j, nn);
        rr    = two_j - quad * nn;
        qn    = div_u64(PI_OVER_2_Q62, nn);
        x     = qn * rr + div_u64((PI_OVER_2_Q62 - qn * nn) * rr, nn);
        x2    = mul_q62(x, x);
        s     = x;
        c     = ONE_Q62;
        ts    = x;
        tc    = ONE_Q62;
        for (i = 1; i <= 16; i++) begin
            ts = div_u64(mul_q62(ts, x2), 64'((2 * i) * (2 * i + 1)));
            tc = div_u64(mul_q62(tc, x2), 64'((2 * i - 1) * (2 * i)));
            if ((i % 2) == 1) begin
                s = s - ts;
                c = c - tc;
            end else begin
                s = s + ts;
                c = c + tc;
            end
        end
        if (quad == 64'd0) begin
            vc = to_q16(c, 1'b0);
            vs = to_q16(s, 1'b0);
        end else if (quad == 64'd1) begin
            vc = to_q16(s, 1'b1);
            vs = to_q16(c, 1'b0);
        end else begin
            vc = -(ROM_W'(1) <<< ROM_FRAC);
            vs = '0;
        end
        return want_sin ? vs : vc;
    endfunction

endpackage

### src/dsq_stream_if.sv
// dsq_in_if / dsq_out_if: valid-ready channels for the quantizer requests
// and results. Depends on dsq_pkg.

interface dsq_in_if;
    import dsq_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] dir_x;
    logic signed [IN_W-1:0] dir_y;
    logic signed [IN_W-1:0] dir_z;
    logic signed [IN_W-1:0] normal_x;
    logic signed [IN_W-1:0] normal_y;
    logic signed [IN_W-1:0] normal_z;

    modport source (
        output valid, dir_x, dir_y, dir_z, normal_x, normal_y, normal_z,
        input  ready
    );
    modport sink (
        input  valid, dir_x, dir_y, dir_z, normal_x, normal_y, normal_z,
        output ready
    );
endinterface

interface dsq_out_if;
    import dsq_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] dir_theta;
    logic [OUT_W-1:0] dir_phi;
    logic [OUT_W-1:0] normal_theta;
    logic [OUT_W-1:0] normal_phi;

    modport source (
        output valid, dir_theta, dir_phi, normal_theta, normal_phi,
        input  ready
    );
    modport sink (
        input  valid, dir_theta, dir_phi, normal_theta, normal_phi,
        output ready
    );
endinterface

### src/direction_to_spherical_bytes_top.sv
// direction_to_spherical_bytes_top: sequences four table searches per request
// and holds the result. Depends on dsq_pkg, dsq_stream_if and dsq_search.

// One request carries a direction and a surface normal in signed fixed point
// with COORD_FRAC_BITS fraction bits; the result carries a polar code
// floor(acos(z)*N/pi) (z clamped to [-1,1]) and an azimuth code
// atan2(y,x)*N/(2pi) wrapped into [0,N) for each vector, N = ANGLE_STEPS,
// low 8 bits kept. A zero normal gives zero normal codes. The block takes one
// request at a time: the four codes are found one after another by a single
// search unit with one table port and one multiplier. A polar search step is
// a midpoint, a table read and a compare, over ceil(log2 N) steps; an azimuth
// step adds two products through the shared multiplier, over up to
// ceil(log2(N/2+1)) steps, 7 or 8 at N = 256; each search also has a start,
// a final midpoint and a completion, and the output register is loaded after
// the last search. Loading waits only while the previous result is still held.
// A new request is taken while the previous result still waits in the output
// register.

module direction_to_spherical_bytes_top #(
    parameter int ANGLE_STEPS     = dsq_pkg::ANGLE_STEPS_DEF,
    parameter int COORD_FRAC_BITS = dsq_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dsq_in_if.sink      i_req,
    dsq_out_if.source   o_rsp
);
    import dsq_pkg::*;

    localparam int CODE_W = $clog2(ANGLE_STEPS);

    typedef enum logic [3:0] {
        TS_IDLE  = 4'b0001,
        TS_START = 4'b0010,
        TS_WAIT  = 4'b0100,
        TS_HOLD  = 4'b1000
    } t_top_state;

    typedef enum logic [1:0] {
        JOB_DIR_POL = 2'd0,
        JOB_DIR_AZ  = 2'd1,
        JOB_NRM_POL = 2'd2,
        JOB_NRM_AZ  = 2'd3
    } t_job;

    t_top_state             r_state;
    t_job                   r_job;
    logic                   r_out_valid;

    logic signed [IN_W-1:0] r_dir_x;
    logic signed [IN_W-1:0] r_dir_y;
    logic signed [IN_W-1:0] r_dir_z;
    logic signed [IN_W-1:0] r_nrm_x;
    logic signed [IN_W-1:0] r_nrm_y;
    logic signed [IN_W-1:0] r_nrm_z;

    logic [OUT_W-1:0]       r_res_dt;
    logic [OUT_W-1:0]       r_res_dp;
    logic [OUT_W-1:0]       r_res_nt;
    logic [OUT_W-1:0]       r_res_np;

    logic [OUT_W-1:0]       r_o_dt;
    logic [OUT_W-1:0]       r_o_dp;
    logic [OUT_W-1:0]       r_o_nt;
    logic [OUT_W-1:0]       r_o_np;

    t_srch_req              w_req;
    t_srch_sts              w_sts;
    logic signed [IN_W-1:0] w_x;
    logic signed [IN_W-1:0] w_y;
    logic [CODE_W-1:0]      w_code;
    logic [OUT_W-1:0]       w_code8;
    logic                   w_nrm_zero;
    logic                   w_load_out;
    logic                   w_last_job;

    // operand select for the current search
    always_comb begin
        case (r_job)
            JOB_DIR_POL: begin w_x = r_dir_z; w_y = r_dir_y; end
            JOB_DIR_AZ:  begin w_x = r_dir_x; w_y = r_dir_y; end
            JOB_NRM_POL: begin w_x = r_nrm_z; w_y = r_nrm_y; end
            JOB_NRM_AZ:  begin w_x = r_nrm_x; w_y = r_nrm_y; end
            default:     begin w_x = r_dir_z; w_y = r_dir_y; end
        endcase
    end

    assign w_req.start = (r_state == TS_START);
    assign w_req.polar = (r_job == JOB_DIR_POL) || (r_job == JOB_NRM_POL);

    dsq_search #(
        .ANGLE_STEPS     (ANGLE_STEPS),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_x     (w_x),
        .i_y     (w_y),
        .o_sts   (w_sts),
        .o_code  (w_code)
    );

    assign w_code8    = OUT_W'(w_code);
    assign w_nrm_zero = (r_nrm_x == '0) && (r_nrm_y == '0) && (r_nrm_z == '0);
    assign w_load_out = (r_state == TS_HOLD) && (!r_out_valid || o_rsp.ready);
    assign w_last_job = (r_job == JOB_NRM_AZ);

    // request sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= TS_IDLE;
            r_job       <= JOB_DIR_POL;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                TS_IDLE: begin
                    if (i_req.valid) begin
                        r_job   <= JOB_DIR_POL;
                        r_state <= TS_START;
                    end
                end
                TS_START: r_state <= TS_WAIT;
                TS_WAIT: begin
                    if (w_sts.done) begin
                        if (w_last_job) begin
                            r_state <= TS_HOLD;
                        end else begin
                            r_job   <= t_job'(r_job + 2'd1);
                            r_state <= TS_START;
                        end
                    end
                end
                TS_HOLD: begin
                    if (w_load_out) begin
                        r_state <= TS_IDLE;
                    end
                end
                default: r_state <= TS_IDLE;
            endcase
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if ((r_state == TS_IDLE) && i_req.valid) begin
            r_dir_x <= i_req.dir_x;
            r_dir_y <= i_req.dir_y;
            r_dir_z <= i_req.dir_z;
            r_nrm_x <= i_req.normal_x;
            r_nrm_y <= i_req.normal_y;
            r_nrm_z <= i_req.normal_z;
        end
    end

    // collect codes as each search finishes
    always_ff @(posedge i_clk) begin
        if ((r_state == TS_WAIT) && w_sts.done) begin
            case (r_job)
                JOB_DIR_POL: r_res_dt <= w_code8;
                JOB_DIR_AZ:  r_res_dp <= w_code8;
                JOB_NRM_POL: r_res_nt <= w_code8;
                JOB_NRM_AZ:  r_res_np <= w_code8;
                default:     ;
            endcase
        end
    end

    // output register, zero normal forces zero codes
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_o_dt <= r_res_dt;
            r_o_dp <= r_res_dp;
            r_o_nt <= w_nrm_zero ? '0 : r_res_nt;
            r_o_np <= w_nrm_zero ? '0 : r_res_np;
        end
    end

    assign i_req.ready        = (r_state == TS_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.dir_theta    = r_o_dt;
    assign o_rsp.dir_phi      = r_o_dp;
    assign o_rsp.normal_theta = r_o_nt;
    assign o_rsp.normal_phi   = r_o_np;

    // a new request is only taken with the search unit at rest
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !w_sts.busy)
        else $error("request accepted while search unit busy");

    // search completions only arrive while the sequencer waits for one
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.done |-> (r_state == TS_WAIT))
        else $error("search completion outside wait state");

    // moving a finished result out always presents it next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> (o_rsp.valid && (r_state == TS_IDLE)))
        else $error("result load did not raise valid");

endmodule

### src/dsq_rom.sv
// dsq_rom: constant cos/sin table of pi*j/ANGLE_STEPS in Q1.16, registered read.
// Depends on dsq_pkg (table builder).

module dsq_rom #(
    parameter int   ANGLE_STEPS = dsq_pkg::ANGLE_STEPS_DEF,
    localparam int  IDX_W       = $clog2(ANGLE_STEPS + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [IDX_W-1:0]                   i_idx,
    output logic signed [dsq_pkg::ROM_W-1:0]   o_cos,
    output logic signed [dsq_pkg::ROM_W-1:0]   o_sin
);
    import dsq_pkg::*;

    logic signed [ROM_W-1:0] w_cos [ANGLE_STEPS+1];
    logic signed [ROM_W-1:0] w_sin [ANGLE_STEPS+1];
    logic signed [ROM_W-1:0] r_cos;
    logic signed [ROM_W-1:0] r_sin;

    // table contents fixed at elaboration
    for (genvar g = 0; g <= ANGLE_STEPS; g++) begin : g_entry
        localparam logic signed [ROM_W-1:0] COS_V = rom_value(g, ANGLE_STEPS, 1'b0);
        localparam logic signed [ROM_W-1:0] SIN_V = rom_value(g, ANGLE_STEPS, 1'b1);
        assign w_cos[g] = COS_V;
        assign w_sin[g] = SIN_V;
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= w_cos[i_idx];
            r_sin <= w_sin[i_idx];
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

### src/dsq_search.sv
// dsq_search: one binary search over the angle table, polar or azimuth, with
// a single shared multiplier. Depends on dsq_pkg and dsq_rom.

module dsq_search #(
    parameter int ANGLE_STEPS     = dsq_pkg::ANGLE_STEPS_DEF,
    parameter int COORD_FRAC_BITS = dsq_pkg::COORD_FRAC_BITS_DEF,
    localparam int CODE_W         = $clog2(ANGLE_STEPS)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dsq_pkg::t_srch_req               i_req,
    input  logic signed [dsq_pkg::IN_W-1:0]  i_x,
    input  logic signed [dsq_pkg::IN_W-1:0]  i_y,
    output dsq_pkg::t_srch_sts               o_sts,
    output logic [CODE_W-1:0]                o_code
);
    import dsq_pkg::*;

    localparam int IDX_W  = $clog2(ANGLE_STEPS + 1);
    localparam int Y_W    = IN_W + 1;
    localparam int PROD_W = ROM_W + Y_W;
    localparam int CMP_W  = IN_W + ROM_W + COORD_FRAC_BITS;

    localparam logic [CODE_W-1:0] HI_POL = CODE_W'(ANGLE_STEPS - 1);
    localparam logic [CODE_W-1:0] HI_AZ  = CODE_W'(ANGLE_STEPS / 2);
    localparam logic [CODE_W-1:0] N_CODE = CODE_W'(ANGLE_STEPS);
    localparam logic signed [CMP_W-1:0] ONE_Z =
        {{(CMP_W-1){1'b0}}, 1'b1} << COORD_FRAC_BITS;

    typedef enum logic [5:0] {
        SR_IDLE = 6'b000001,
        SR_MID  = 6'b000010,
        SR_ROM  = 6'b000100,
        SR_MULA = 6'b001000,
        SR_MULB = 6'b010000,
        SR_DEC  = 6'b100000
    } t_sr_state;

    t_sr_state                r_state;
    logic                     r_done;
    logic                     r_polar;
    logic                     r_neg;
    logic [CODE_W-1:0]        r_lo;
    logic [CODE_W-1:0]        r_hi;
    logic [CODE_W-1:0]        r_mid;
    logic [CODE_W-1:0]        r_code;
    logic signed [IN_W-1:0]   r_x;
    logic signed [Y_W-1:0]    r_y;
    logic signed [CMP_W-1:0]  r_zs;
    logic signed [PROD_W-1:0] r_pa;
    logic signed [PROD_W-1:0] r_pb;

    logic [CODE_W:0]          w_mid_sum;
    logic [CODE_W+1:0]        w_idx_wide;
    logic [IDX_W-1:0]         w_idx;
    logic signed [ROM_W-1:0]  w_c;
    logic signed [ROM_W-1:0]  w_s;
    logic signed [ROM_W-1:0]  w_ma;
    logic signed [Y_W-1:0]    w_mb;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W:0]   w_cr;
    logic signed [CMP_W-1:0]  w_cs;
    logic signed [CMP_W-1:0]  w_z;
    logic signed [CMP_W-1:0]  w_zc;
    logic signed [Y_W-1:0]    w_y_ext;
    logic                     w_dot_pos;
    logic                     w_take;
    logic [CODE_W-1:0]        w_final;

    // table index: polar reads entry mid, azimuth reads entry 2*mid
    assign w_mid_sum  = (CODE_W+1)'(r_lo) + (CODE_W+1)'(r_hi) + (CODE_W+1)'(1);
    assign w_idx_wide = r_polar ? (CODE_W+2)'(r_mid) : ((CODE_W+2)'(r_mid) << 1);
    assign w_idx      = w_idx_wide[IDX_W-1:0];

    dsq_rom #(
        .ANGLE_STEPS (ANGLE_STEPS)
    ) u_rom (
        .i_clk (i_clk),
        .i_en  (r_state == SR_ROM),
        .i_idx (w_idx),
        .o_cos (w_c),
        .o_sin (w_s)
    );

    // shared multiplier: s*x first, then c*y
    assign w_ma   = (r_state == SR_MULA) ? w_s : w_c;
    assign w_mb   = (r_state == SR_MULA) ? Y_W'(r_x) : r_y;
    assign w_prod = PROD_W'(w_ma) * PROD_W'(w_mb);

    // azimuth test: cross product sign, on a tie the vector must point along the ray
    assign w_cr      = (PROD_W+1)'(r_pb) - (PROD_W+1)'(r_pa);
    assign w_dot_pos = (w_s > 0) ? (r_y != '0)
                                 : (((w_c > 0) && (r_x > 0)) || ((w_c < 0) && (r_x < 0)));

    // polar test: z * 2^16 <= cos * 2^frac
    assign w_cs   = CMP_W'(w_c) <<< COORD_FRAC_BITS;
    assign w_take = r_polar ? (r_zs <= w_cs)
                            : ((w_cr > 0) || ((w_cr == '0) && w_dot_pos));

    // operand conditioning at load
    assign w_y_ext = Y_W'(i_y);
    assign w_z     = CMP_W'(i_x);
    assign w_zc    = (w_z > ONE_Z) ? ONE_Z : ((w_z < -ONE_Z) ? -ONE_Z : w_z);

    // lower half plane folds back onto the upper one
    assign w_final = (!r_polar && r_neg && (r_lo != '0)) ? (N_CODE - r_lo) : r_lo;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SR_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                SR_IDLE: if (i_req.start) r_state <= SR_MID;
                SR_MID: begin
                    if (r_lo >= r_hi) begin
                        r_done  <= 1'b1;
                        r_state <= SR_IDLE;
                    end else begin
                        r_state <= SR_ROM;
                    end
                end
                SR_ROM:  r_state <= r_polar ? SR_DEC : SR_MULA;
                SR_MULA: r_state <= SR_MULB;
                SR_MULB: r_state <= SR_DEC;
                SR_DEC:  r_state <= SR_MID;
                default: r_state <= SR_IDLE;
            endcase
        end
    end

    // search datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            SR_IDLE: begin
                if (i_req.start) begin
                    r_polar <= i_req.polar;
                    r_lo    <= '0;
                    r_hi    <= i_req.polar ? HI_POL : HI_AZ;
                    r_x     <= i_x;
                    r_neg   <= i_y[IN_W-1];
                    r_y     <= i_y[IN_W-1] ? -w_y_ext : w_y_ext;
                    r_zs    <= w_zc <<< ROM_FRAC;
                end
            end
            SR_MID: begin
                r_mid <= w_mid_sum[CODE_W:1];
                if (r_lo >= r_hi) r_code <= w_final;
            end
            SR_MULA: r_pa <= w_prod;
            SR_MULB: r_pb <= w_prod;
            SR_DEC: begin
                if (w_take) r_lo <= r_mid;
                else        r_hi <= r_mid - CODE_W'(1);
            end
            default: ;
        endcase
    end

    assign o_sts.busy = (r_state != SR_IDLE);
    assign o_sts.done = r_done;
    assign o_code     = r_code;

endmodule

### verif/dsq_code_check.sv
// dsq_code_check: watches the request and result channels of the spherical
// quantizer, predicts the four angle codes of each request and compares them.
// Depends on dsq_pkg and dsq_stream_if.
`timescale 1ns / 100ps

module dsq_code_check #(
    parameter int STEPS     = dsq_pkg::ANGLE_STEPS_DEF,
    parameter int FRAC_BITS = dsq_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dsq_in_if    i_req,
    dsq_out_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);
    import dsq_pkg::*;

    typedef logic signed [IN_W-1:0] t_coord;

    typedef struct packed {
        logic [OUT_W-1:0] dir_theta;
        logic [OUT_W-1:0] dir_phi;
        logic [OUT_W-1:0] normal_theta;
        logic [OUT_W-1:0] normal_phi;
    } t_codes;

    // cos and sin of pi*j/STEPS, Q1.16
    int     cos_q16 [0:STEPS];
    int     sin_q16 [0:STEPS];

    t_codes codes_due [$];
    t_codes oldest;
    int     fail_total;
    int     outstanding;
    int     compared;

    assign o_fail_count = fail_total;
    assign o_pending    = outstanding;
    assign o_checked    = compared;

    // (a * b) >> 62 on unsigned Q62 operands
    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = 128'(a) * 128'(b);
        return prod[125:62];
    endfunction

    // Q62 magnitude to Q1.16, round to nearest
    function automatic int q62_to_q16(input logic [63:0] v, input logic neg);
        logic [63:0] r;
        r = (v + (64'd1 << 45)) >> 46;
        return neg ? -int'(r[31:0]) : int'(r[31:0]);
    endfunction

    // one table row from a 17-term Taylor series at 62 fraction bits
    function automatic void angle_entry(input int j, output int cos_v, output int sin_v);
        logic [63:0] n;
        logic [63:0] two_j;
        logic [63:0] quad;
        logic [63:0] rem;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] s;
        logic [63:0] c;
        logic [63:0] ts;
        logic [63:0] tc;
        n     = 64'(STEPS);
        two_j = 64'(2 * j);
        quad  = two_j / n;
        rem   = two_j % n;
        x     = (PI_OVER_2_Q62 / n) * rem + ((PI_OVER_2_Q62 % n) * rem) / n;
        x2    = q62_mul(x, x);
        s     = x;
        c     = ONE_Q62;
        ts    = x;
        tc    = ONE_Q62;
        for (int i = 1; i <= 16; i++) begin
            ts = q62_mul(ts, x2) / 64'((2 * i) * (2 * i + 1));
            tc = q62_mul(tc, x2) / 64'((2 * i - 1) * (2 * i));
            if (i % 2 == 1) begin
                s = s - ts;
                c = c - tc;
            end else begin
                s = s + ts;
                c = c + tc;
            end
        end
        if (quad == 64'd0) begin
            cos_v = q62_to_q16(c, 1'b0);
            sin_v = q62_to_q16(s, 1'b0);
        end else if (quad == 64'd1) begin
            cos_v = q62_to_q16(s, 1'b1);
            sin_v = q62_to_q16(c, 1'b0);
        end else begin
            cos_v = -65536;
            sin_v = 0;
        end
    endfunction

    initial begin
        for (int k = 0; k <= STEPS; k++) angle_entry(k, cos_q16[k], sin_q16[k]);
    end

    // largest k with clamped z at or below cos(pi*k/N)
    function automatic logic [OUT_W-1:0] polar_code(input t_coord z_in);
        longint one;
        longint z;
        int     lo;
        int     hi;
        int     mid;
        one = longint'(1) <<< FRAC_BITS;
        z   = z_in;
        if (z > one) z = one;
        if (z < -one) z = -one;
        z  = z * 65536;
        lo = 0;
        hi = STEPS - 1;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (z <= longint'(cos_q16[mid]) * one) lo = mid;
            else hi = mid - 1;
        end
        return OUT_W'(lo);
    endfunction

    // last table ray at or clockwise of (x, |y|), mirrored for the lower half
    function automatic logic [OUT_W-1:0] azimuth_code(input t_coord x_in, input t_coord y_in);
        longint x;
        longint y;
        longint c;
        longint s;
        longint cr;
        longint dt;
        logic   lower;
        int     lo;
        int     hi;
        int     mid;
        x     = x_in;
        y     = y_in;
        lower = (y < 0);
        if (lower) y = -y;
        lo = 0;
        hi = STEPS / 2;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            c   = cos_q16[2 * mid];
            s   = sin_q16[2 * mid];
            cr  = c * y - s * x;
            dt  = c * x + s * y;
            if (cr > 0 || (cr == 0 && dt > 0)) lo = mid;
            else hi = mid - 1;
        end
        if (lower && lo != 0) lo = STEPS - lo;
        return OUT_W'(lo);
    endfunction

    function automatic t_codes spherical_codes(input t_coord dx, input t_coord dy,
                                               input t_coord dz, input t_coord nx,
                                               input t_coord ny, input t_coord nz);
        t_codes r;
        r.dir_theta = polar_code(dz);
        r.dir_phi   = azimuth_code(dx, dy);
        // a zero normal carries no angle
        if (nx == 0 && ny == 0 && nz == 0) begin
            r.normal_theta = '0;
            r.normal_phi   = '0;
        end else begin
            r.normal_theta = polar_code(nz);
            r.normal_phi   = azimuth_code(nx, ny);
        end
        return r;
    endfunction

    task automatic report_fail(input string msg);
        $display("[%0t] error: %s", $time, msg);
        fail_total++;
    endtask

    task automatic check_field(input string name, input logic [OUT_W-1:0] got,
                               input logic [OUT_W-1:0] want);
        if (got !== want)
            report_fail($sformatf("%s got %0d, expected %0d (result %0d)",
                                  name, got, want, compared));
    endtask

    initial begin
        fail_total  = 0;
        outstanding = 0;
        compared    = 0;
    end

    // results first, since a result never belongs to a request of the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (codes_due.size() == 0) begin
                    report_fail("result with no request outstanding");
                end else begin
                    oldest = codes_due.pop_front();
                    outstanding--;
                    check_field("dir_theta", i_rsp.dir_theta, oldest.dir_theta);
                    check_field("dir_phi", i_rsp.dir_phi, oldest.dir_phi);
                    check_field("normal_theta", i_rsp.normal_theta, oldest.normal_theta);
                    check_field("normal_phi", i_rsp.normal_phi, oldest.normal_phi);
                    compared++;
                end
            end
            if (i_req.valid && i_req.ready) begin
                codes_due.push_back(spherical_codes(i_req.dir_x, i_req.dir_y, i_req.dir_z,
                                                    i_req.normal_x, i_req.normal_y,
                                                    i_req.normal_z));
                outstanding++;
            end
        end
    end

endmodule

### verif/testbench.sv
// testbench: drives direction/normal requests into the spherical quantizer under
// several idling patterns and gives the verdict. Depends on dsq_pkg,
// dsq_stream_if, direction_to_spherical_bytes_top and dsq_code_check.
`timescale 1ns / 100ps

module testbench;
    import dsq_pkg::*;

    typedef logic signed [IN_W-1:0] t_coord;

    localparam int CLK_HALF_NS  = 5;
    localparam int RESET_CYCLES = 7;
    localparam int PHASE_ITEMS  = 388;
    localparam int DRAIN_CYCLES = 300;
    localparam int LIMIT_CYCLES = 2_000_000;

    localparam t_coord P1   = 16'sd16384;
    localparam t_coord M1   = -16'sd16384;
    localparam t_coord DIAG = 16'sd11585;
    localparam t_coord MAXP = 16'sh7fff;
    localparam t_coord MAXN = 16'sh8000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int requests_sent  = 0;
    int directed_count = 0;
    int cycle_count    = 0;
    int fail_count;
    int pending;
    int checked;

    dsq_in_if  req_ch ();
    dsq_out_if rsp_ch ();

    direction_to_spherical_bytes_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    dsq_code_check code_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #CLK_HALF_NS i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input t_coord dx, input t_coord dy, input t_coord dz,
                                input t_coord nx, input t_coord ny, input t_coord nz);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.dir_x    <= dx;
        req_ch.dir_y    <= dy;
        req_ch.dir_z    <= dz;
        req_ch.normal_x <= nx;
        req_ch.normal_y <= ny;
        req_ch.normal_z <= nz;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        requests_sent++;
        @(negedge i_clk);
    endtask

    // hold off until every outstanding result has come back
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic send_random();
        t_coord v [6];
        int     kind;
        kind = $urandom_range(99);
        for (int k = 0; k < 6; k++) begin
            if (kind < 62) begin
                // in-range components
                v[k] = t_coord'(int'($urandom_range(32768)) - 16384);
            end else if (kind < 77) begin
                // anything the field holds, out-of-range z included
                v[k] = t_coord'($urandom);
            end else begin
                // axes, extremes and tiny components
                case ($urandom_range(7))
                    0: v[k] = '0;
                    1: v[k] = P1;
                    2: v[k] = M1;
                    3: v[k] = 16'sd1;
                    4: v[k] = -16'sd1;
                    5: v[k] = MAXP;
                    6: v[k] = MAXN;
                    default: v[k] = t_coord'(int'($urandom_range(64)) - 32);
                endcase
            end
        end
        // zero normal now and then
        if (kind % 9 == 0) begin
            v[3] = '0;
            v[4] = '0;
            v[5] = '0;
        end
        send_request(v[0], v[1], v[2], v[3], v[4], v[5]);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.dir_x    = '0;
        req_ch.dir_y    = '0;
        req_ch.dir_z    = '0;
        req_ch.normal_x = '0;
        req_ch.normal_y = '0;
        req_ch.normal_z = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: zero vectors, axes, clamp of z, extremes, diagonals
        send_request('0, '0, '0, '0, '0, '0);
        send_request(P1, '0, '0, '0, '0, P1);
        send_request(M1, '0, '0, M1, '0, '0);
        send_request('0, P1, '0, '0, M1, '0);
        send_request('0, M1, P1, '0, P1, M1);
        send_request('0, '0, M1, '0, '0, 16'sd1);
        send_request('0, '0, MAXP, 16'sd1, '0, '0);
        send_request('0, '0, MAXN, '0, -16'sd1, '0);
        send_request(MAXP, MAXP, MAXP, MAXN, MAXN, MAXN);
        send_request(MAXN, MAXP, 16'sd16385, MAXP, MAXN, -16'sd16385);
        send_request(M1, -16'sd1, '0, M1, 16'sd1, '0);
        send_request(DIAG, DIAG, '0, -DIAG, DIAG, DIAG);
        send_request(-DIAG, -DIAG, DIAG, DIAG, -DIAG, -DIAG);
        send_request(16'sd1, 16'sd1, 16'sd1, -16'sd1, -16'sd1, -16'sd1);
        send_request(P1, -16'sd1, '0, P1, 16'sd1, '0);
        send_request(16'sd5, '0, '0, '0, '0, '0);
        send_request('0, '0, '0, '0, '0, M1);
        send_request(MAXN, '0, '0, MAXN, '0, '0);
        send_request(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa);
        send_request(16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555);
        directed_count = requests_sent;
        drain_results();

        // random, one idling pattern per phase
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 86;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 86;
                end
                default: begin
                    send_idle_pct  = 22;
                    recv_stall_pct = 22;
                end
            endcase
            repeat (PHASE_ITEMS) send_random();
            drain_results();
        end

        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d requests: %0d directed, the rest random over four idling phases",
                 requests_sent, directed_count);
        $display("%0d results compared, %0d mismatches", checked, fail_count);
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### files.f
src/dsq_pkg.sv
src/dsq_stream_if.sv
src/dsq_rom.sv
src/dsq_search.sv
src/direction_to_spherical_bytes_top.sv
verif/dsq_code_check.sv
verif/testbench.sv
